>>> rtl/lli_pkg.sv
package lli_pkg;

  // default fraction bits of the fixed point format
  localparam int unsigned FracBitsDef = 16;

  // field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned EpsW   = 31;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned MulW   = 2 * CoordW;
  localparam int unsigned ProdW  = MulW + 1;
  localparam int unsigned CrossW = ProdW + 1;
  localparam int unsigned NumW   = ProdW + CoordW + 2;

  // quotient bits kept by the divider, one more than a coordinate
  localparam int unsigned QuoW   = CoordW + 1;
  localparam int unsigned DivLat = QuoW + 1;

  // result status codes
  localparam logic [1:0] StatusSingle     = 2'd0;
  localparam logic [1:0] StatusCoincident = 2'd1;
  localparam logic [1:0] StatusParallel   = 2'd2;

  // sideband that travels with a quotient through the divider
  typedef struct packed {
    logic neg;
    logic sat;
    logic zero;
  } div_ctl_t;

endpackage

>>> rtl/lli_div.sv
module lli_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [lli_pkg::NumW-1:0]       num_i,
  input  logic [lli_pkg::ProdW-1:0]      den_i,
  input  lli_pkg::div_ctl_t              ctl_i,
  output logic [lli_pkg::CoordW-1:0]     quo_o,
  output logic                           ovf_o
);

  localparam int unsigned NumW   = lli_pkg::NumW;
  localparam int unsigned ProdW  = lli_pkg::ProdW;
  localparam int unsigned QuoW   = lli_pkg::QuoW;
  localparam int unsigned CoordW = lli_pkg::CoordW;
  localparam logic [QuoW-1:0] MaxPos = QuoW'((64'd1 << (CoordW - 1)) - 64'd1);
  localparam logic [QuoW-1:0] MaxNeg = QuoW'(64'd1 << (CoordW - 1));

  logic [NumW-1:0]   rem_q [QuoW];
  logic [QuoW-1:0]   quo_q [QuoW];
  logic [ProdW-1:0]  den_q [QuoW];
  lli_pkg::div_ctl_t ctl_q [QuoW];

  // one restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int unsigned Bit = QuoW - 1 - k;
    logic [NumW-1:0]   rem_in, shifted, rem_d;
    logic [QuoW-1:0]   quo_in, quo_d;
    logic [ProdW-1:0]  den_in;
    lli_pkg::div_ctl_t ctl_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    always_comb begin
      shifted = NumW'(den_in) << Bit;
      ge      = (rem_in >= shifted);
      rem_d   = ge ? (rem_in - shifted) : rem_in;
      quo_d   = quo_in | (QuoW'(ge) << Bit);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  // sign, saturation and masking of the final quotient
  logic [QuoW-1:0]   quo_fin;
  lli_pkg::div_ctl_t ctl_fin;
  logic              sat;
  logic [CoordW-1:0] quo_d;
  logic              ovf_d;

  always_comb begin
    quo_fin = quo_q[QuoW-1];
    ctl_fin = ctl_q[QuoW-1];
    sat     = ctl_fin.sat || (!ctl_fin.neg && (quo_fin > MaxPos))
              || (ctl_fin.neg && (quo_fin > MaxNeg));
    if (ctl_fin.zero) begin
      quo_d = '0;
    end else if (sat) begin
      quo_d = ctl_fin.neg ? MaxNeg[CoordW-1:0] : MaxPos[CoordW-1:0];
    end else begin
      quo_d = ctl_fin.neg ? (CoordW'(0) - quo_fin[CoordW-1:0]) : quo_fin[CoordW-1:0];
    end
    ovf_d = !ctl_fin.zero && sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

>>> rtl/line_line_intersection.sv
// Two-line intersection by Cramer's rule in signed fixed point.
// Input item on s_axis: two lines, each a direction vector and a point it
// passes through. Result item on m_axis: intersection point, status
// (single, coincident, parallel) and a saturation flag.
// epsilon is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle, which the block does not enforce. It is scaled by
// the fraction bits and compared against |det| and against the cross product
// that tells coincident from parallel lines. On its way to the result an item
// passes registers for 32x32 and 33x32 products, coefficient sums, partial
// products against the line constants, numerator sums, magnitude and range
// check, then a 33-stage restoring divider (one quotient bit per stage) and
// its saturation register. Throughput: one item per cycle while the receiver
// does not stall; two dividers run side by side for x and y. Reset clears all
// valid bits and sets epsilon to 1; the pipeline comes up empty. When the
// receiver stalls the whole pipeline holds in place and s_axis_tready drops
// while a result waits; nothing is lost or repeated.
module line_line_intersection #(
  parameter int unsigned FRAC_BITS = lli_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // dir_a_x, dir_a_y, point_a_x, point_a_y, dir_b_x, dir_b_y, point_b_x,
  // point_b_y, 32 bits each from the lowest bit up
  input  logic [255:0]                 s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // cross_x, cross_y
  output logic [63:0]                  m_axis_tdata,
  // status, overflow
  output logic [2:0]                   m_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_we_i,
  input  logic [lli_pkg::EpsW-1:0]     cfg_wdata_i
);

  localparam int unsigned CoordW  = lli_pkg::CoordW;
  localparam int unsigned DiffW   = lli_pkg::DiffW;
  localparam int unsigned MulW    = lli_pkg::MulW;
  localparam int unsigned ProdW   = lli_pkg::ProdW;
  localparam int unsigned CrossW  = lli_pkg::CrossW;
  localparam int unsigned NumW    = lli_pkg::NumW;
  localparam int unsigned QuoW    = lli_pkg::QuoW;
  localparam int unsigned EpsW    = lli_pkg::EpsW;
  localparam int unsigned ThrW    = EpsW + FRAC_BITS;
  localparam int unsigned PipeLat = 5 + lli_pkg::DivLat;
  localparam int unsigned StLen   = 2 + lli_pkg::DivLat;

  logic en;
  logic [PipeLat-1:0] vld_q;

  // the whole pipeline advances unless a result waits on a stalled receiver
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // epsilon register
  logic [EpsW-1:0] eps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsW'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], s_axis_tvalid};
    end
  end

  // input fields
  logic signed [CoordW-1:0] dax, day, pax, pay, dbx, dby, pbx, pby;
  assign dax = s_axis_tdata[31:0];
  assign day = s_axis_tdata[63:32];
  assign pax = s_axis_tdata[95:64];
  assign pay = s_axis_tdata[127:96];
  assign dbx = s_axis_tdata[159:128];
  assign dby = s_axis_tdata[191:160];
  assign pbx = s_axis_tdata[223:192];
  assign pby = s_axis_tdata[255:224];

  // stage 1: direct products
  logic signed [MulW-1:0]   m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  logic signed [ProdW-1:0]  m7_q, m8_q;
  logic signed [CoordW-1:0] s1_dax_q, s1_day_q, s1_dbx_q, s1_dby_q;
  logic signed [DiffW-1:0]  dpx, dpy;

  assign dpx = DiffW'(pbx) - DiffW'(pax);
  assign dpy = DiffW'(pby) - DiffW'(pay);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q     <= day * pax;
      m2_q     <= dax * pay;
      m3_q     <= dby * pbx;
      m4_q     <= dbx * pby;
      m5_q     <= dax * dby;
      m6_q     <= day * dbx;
      m7_q     <= dpx * day;
      m8_q     <= dpy * dax;
      s1_dax_q <= dax;
      s1_day_q <= day;
      s1_dbx_q <= dbx;
      s1_dby_q <= dby;
    end
  end

  // stage 2: line constants, determinant, cross product
  logic signed [ProdW-1:0]  c1_q, c2_q, det_q;
  logic signed [CrossW-1:0] cr_q;
  logic signed [CoordW-1:0] s2_dax_q, s2_day_q, s2_dbx_q, s2_dby_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= ProdW'(m1_q) - ProdW'(m2_q);
      c2_q     <= ProdW'(m3_q) - ProdW'(m4_q);
      det_q    <= ProdW'(m5_q) - ProdW'(m6_q);
      cr_q     <= CrossW'(m7_q) - CrossW'(m8_q);
      s2_dax_q <= s1_dax_q;
      s2_day_q <= s1_day_q;
      s2_dbx_q <= s1_dbx_q;
      s2_dby_q <= s1_dby_q;
    end
  end

  // stage 3: near-zero tests and partial products against the constants
  logic [ThrW-1:0]          thr;
  logic [ProdW-1:0]         det_mag;
  logic [CrossW-1:0]        cr_mag;
  logic                     det_zero, cr_zero;
  logic [1:0]               status_d;
  logic signed [DiffW-1:0]  c1_hi, c2_hi, c1_lo, c2_lo;

  always_comb begin
    thr      = {eps_q, {FRAC_BITS{1'b0}}};
    det_mag  = det_q[ProdW-1] ? (ProdW'(0) - det_q) : det_q;
    cr_mag   = cr_q[CrossW-1] ? (CrossW'(0) - cr_q) : cr_q;
    det_zero = ({1'b0, det_mag} <= CrossW'(thr));
    cr_zero  = (cr_mag <= CrossW'(thr));
    priority if (!det_zero) begin
      status_d = lli_pkg::StatusSingle;
    end else if (cr_zero) begin
      status_d = lli_pkg::StatusCoincident;
    end else begin
      status_d = lli_pkg::StatusParallel;
    end
    c1_hi = c1_q[ProdW-1:CoordW];
    c2_hi = c2_q[ProdW-1:CoordW];
    c1_lo = {1'b0, c1_q[CoordW-1:0]};
    c2_lo = {1'b0, c2_q[CoordW-1:0]};
  end

  logic signed [ProdW-1:0] xa_hi_q, xa_lo_q, xb_hi_q, xb_lo_q;
  logic signed [ProdW-1:0] ya_hi_q, ya_lo_q, yb_hi_q, yb_lo_q;
  logic [ProdW-1:0]        s3_den_q;
  logic                    s3_den_neg_q;
  logic [1:0]              s3_status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_hi_q      <= s2_dax_q * c2_hi;
      xa_lo_q      <= s2_dax_q * c2_lo;
      xb_hi_q      <= s2_dbx_q * c1_hi;
      xb_lo_q      <= s2_dbx_q * c1_lo;
      ya_hi_q      <= s2_day_q * c2_hi;
      ya_lo_q      <= s2_day_q * c2_lo;
      yb_hi_q      <= s2_dby_q * c1_hi;
      yb_lo_q      <= s2_dby_q * c1_lo;
      s3_den_q     <= det_mag;
      s3_den_neg_q <= det_q[ProdW-1];
      s3_status_q  <= status_d;
    end
  end

  // stage 4: numerators, x = dax*c2 - dbx*c1, y = day*c2 - dby*c1
  logic signed [ProdW:0]  hx, lx, hy, ly;
  logic signed [NumW-1:0] num_x_q, num_y_q;
  logic [ProdW-1:0]       s4_den_q;
  logic                   s4_den_neg_q;

  always_comb begin
    hx = (ProdW+1)'(xa_hi_q) - (ProdW+1)'(xb_hi_q);
    lx = (ProdW+1)'(xa_lo_q) - (ProdW+1)'(xb_lo_q);
    hy = (ProdW+1)'(ya_hi_q) - (ProdW+1)'(yb_hi_q);
    ly = (ProdW+1)'(ya_lo_q) - (ProdW+1)'(yb_lo_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q      <= (NumW'(hx) <<< CoordW) + NumW'(lx);
      num_y_q      <= (NumW'(hy) <<< CoordW) + NumW'(ly);
      s4_den_q     <= s3_den_q;
      s4_den_neg_q <= s3_den_neg_q;
    end
  end

  // stage 5: magnitudes, quotient sign and early range check
  logic [NumW-1:0]   mag_x, mag_y, den_lim;
  lli_pkg::div_ctl_t ctl_x_d, ctl_y_d, ctl_x_q, ctl_y_q;
  logic [NumW-1:0]   mag_x_q, mag_y_q;
  logic [ProdW-1:0]  s5_den_q;
  logic [1:0]        st_line_q [StLen];

  always_comb begin
    mag_x        = num_x_q[NumW-1] ? (NumW'(0) - num_x_q) : num_x_q;
    mag_y        = num_y_q[NumW-1] ? (NumW'(0) - num_y_q) : num_y_q;
    den_lim      = NumW'(s4_den_q) << QuoW;
    ctl_x_d.neg  = num_x_q[NumW-1] ^ s4_den_neg_q;
    ctl_x_d.sat  = (mag_x >= den_lim);
    ctl_x_d.zero = (st_line_q[0] != lli_pkg::StatusSingle);
    ctl_y_d.neg  = num_y_q[NumW-1] ^ s4_den_neg_q;
    ctl_y_d.sat  = (mag_y >= den_lim);
    ctl_y_d.zero = (st_line_q[0] != lli_pkg::StatusSingle);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_x_q  <= mag_x;
      mag_y_q  <= mag_y;
      ctl_x_q  <= ctl_x_d;
      ctl_y_q  <= ctl_y_d;
      s5_den_q <= s4_den_q;
    end
  end

  // status follows its item down to the output
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_line_q[0] <= s3_status_q;
      for (int i = 1; i < StLen; i++) begin
        st_line_q[i] <= st_line_q[i-1];
      end
    end
  end

  // dividers for x and y
  logic [CoordW-1:0] cross_x, cross_y;
  logic              ovf_x, ovf_y;

  lli_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mag_x_q),
    .den_i (s5_den_q),
    .ctl_i (ctl_x_q),
    .quo_o (cross_x),
    .ovf_o (ovf_x)
  );

  lli_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mag_y_q),
    .den_i (s5_den_q),
    .ctl_i (ctl_y_q),
    .quo_o (cross_y),
    .ovf_o (ovf_y)
  );

  // result item
  assign m_axis_tvalid = vld_q[PipeLat-1];
  assign m_axis_tdata  = {cross_y, cross_x};
  assign m_axis_tuser  = {ovf_x | ovf_y, st_line_q[StLen-1]};

endmodule

>>> rtl/lli_checker.sv
module lli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // status is always one of the known codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser[1:0] == lli_pkg::StatusSingle)
      || (m_axis_tuser[1:0] == lli_pkg::StatusCoincident)
      || (m_axis_tuser[1:0] == lli_pkg::StatusParallel)))
    else $error("invalid status code on result item");

  // parallel or coincident results carry zero coordinates and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[1:0] != lli_pkg::StatusSingle))
      |-> ((m_axis_tdata == '0) && !m_axis_tuser[2]))
    else $error("non-single result with nonzero payload");

  // overflow means at least one coordinate sits at a saturation bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2])
      |-> ((m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000)
        || (m_axis_tdata[63:32] == 32'h7FFF_FFFF) || (m_axis_tdata[63:32] == 32'h8000_0000)))
    else $error("overflow flag without saturated coordinate");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result item changed");

endmodule

bind line_line_intersection lli_checker u_lli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
